// File: src/mrht_pkg.sv
// ----------------------------------------------------------------------------
// mrht_pkg
// Shared types and constants for the missing range hole tracker.
// ----------------------------------------------------------------------------
package mrht_pkg;

	localparam int MAX_HOLES = 16;
	localparam int IDX_BITS  = 32;
	localparam int IDX_W     = $clog2(MAX_HOLES);
	localparam int CNT_W     = $clog2(MAX_HOLES + 1);

	localparam logic [IDX_BITS-1:0] IDX_ONE = {{(IDX_BITS-1){1'b0}}, 1'b1};

	// request operations
	localparam logic OP_START = 1'b0;
	localparam logic OP_FILL  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_BEFORE = 3'd2;
	localparam logic [2:0] ST_PAST   = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	// table update commands
	localparam logic [2:0] TBL_NONE      = 3'd0;
	localparam logic [2:0] TBL_LOAD0     = 3'd1;
	localparam logic [2:0] TBL_SET_START = 3'd2;
	localparam logic [2:0] TBL_SET_END   = 3'd3;
	localparam logic [2:0] TBL_SPLIT     = 3'd4;
	localparam logic [2:0] TBL_DROP      = 3'd5;

	typedef struct packed {
		logic                operation;
		logic [IDX_BITS-1:0] range_first;
		logic [IDX_BITS-1:0] range_last;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [IDX_BITS-1:0] conflict_first;
		logic [IDX_BITS-1:0] conflict_last;
		logic [CNT_W-1:0]    holes_left;
		logic                complete;
	} rsp_t;

	typedef struct packed {
		logic [2:0]          op;
		logic [IDX_W-1:0]    idx;
		logic [IDX_BITS-1:0] val_a;
		logic [IDX_BITS-1:0] val_b;
	} tbl_cmd_t;

endpackage

// File: src/mrht_alu.sv
// ----------------------------------------------------------------------------
// mrht_alu
// Shared compare and increment/decrement unit used by the sequencer.
// ----------------------------------------------------------------------------
module mrht_alu (
	input  logic [mrht_pkg::IDX_BITS-1:0] a,
	input  logic [mrht_pkg::IDX_BITS-1:0] b,
	input  logic [mrht_pkg::IDX_BITS-1:0] c,
	input  logic                          dec,
	output logic                          lt,
	output logic                          eq,
	output logic [mrht_pkg::IDX_BITS-1:0] adj
);

	assign lt  = a < b;
	assign eq  = a == b;
	assign adj = dec ? (c - mrht_pkg::IDX_ONE) : (c + mrht_pkg::IDX_ONE);

endmodule

// File: src/mrht_table.sv
// ----------------------------------------------------------------------------
// mrht_table
// Sorted hole table: one read port, load of entry 0, in-place trim, split and drop updates.
// ----------------------------------------------------------------------------
module mrht_table (
	input  logic                          clk,
	input  mrht_pkg::tbl_cmd_t            cmd,
	input  logic [mrht_pkg::IDX_W-1:0]    rd_idx,
	output logic [mrht_pkg::IDX_BITS-1:0] rd_start,
	output logic [mrht_pkg::IDX_BITS-1:0] rd_end
);

	logic [mrht_pkg::IDX_BITS-1:0] start_q [mrht_pkg::MAX_HOLES];
	logic [mrht_pkg::IDX_BITS-1:0] end_q   [mrht_pkg::MAX_HOLES];
	logic [mrht_pkg::CNT_W-1:0]    cur;
	logic [mrht_pkg::CNT_W-1:0]    nxt;

	assign rd_start = start_q[rd_idx];
	assign rd_end   = end_q[rd_idx];
	assign cur      = mrht_pkg::CNT_W'(cmd.idx);
	assign nxt      = cur + mrht_pkg::CNT_W'(1);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mrht_pkg::TBL_NONE: begin
			end
			mrht_pkg::TBL_LOAD0: begin
				start_q[0] <= cmd.val_a;
				end_q[0]   <= cmd.val_b;
			end
			mrht_pkg::TBL_SET_START: begin
				start_q[cmd.idx] <= cmd.val_a;
			end
			mrht_pkg::TBL_SET_END: begin
				end_q[cmd.idx] <= cmd.val_a;
			end
			mrht_pkg::TBL_SPLIT: begin
				end_q[cmd.idx] <= cmd.val_a;
				for (int k = 1; k < mrht_pkg::MAX_HOLES; k++) begin
					if (mrht_pkg::CNT_W'(k) == nxt) begin
						start_q[k] <= cmd.val_b;
						end_q[k]   <= end_q[cmd.idx];
					end else if (mrht_pkg::CNT_W'(k) > nxt) begin
						start_q[k] <= start_q[k-1];
						end_q[k]   <= end_q[k-1];
					end
				end
			end
			mrht_pkg::TBL_DROP: begin
				for (int k = 0; k < mrht_pkg::MAX_HOLES - 1; k++) begin
					if (mrht_pkg::CNT_W'(k) >= cur) begin
						start_q[k] <= start_q[k+1];
						end_q[k]   <= end_q[k+1];
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/missing_range_hole_tracker.sv
// ----------------------------------------------------------------------------
// missing_range_hole_tracker
// Tracks the sorted list of missing block ranges; start and fill requests.
// ----------------------------------------------------------------------------
// Sequencing: a start request, or a fill that needs no search, goes from idle
//   straight to the reply state; other fills scan the holes with the shared
//   compare unit, then the before, past, front, trim/back and split states.
// Throughput: one request at a time; busy is high until the result strobe.
// Reset: asynchronous, clears the sequencer and empties the hole table.
// The receiver cannot stall: done marks each result and rsp holds it until the next.
module missing_range_hole_tracker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mrht_pkg::req_t   req,
	output logic             done,
	output mrht_pkg::rsp_t   rsp
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SEARCH = 4'd1;
	localparam logic [3:0] S_BEFORE = 4'd2;
	localparam logic [3:0] S_PAST   = 4'd3;
	localparam logic [3:0] S_FRONT  = 4'd4;
	localparam logic [3:0] S_TRIM   = 4'd5;
	localparam logic [3:0] S_BACK   = 4'd6;
	localparam logic [3:0] S_SPLIT  = 4'd7;
	localparam logic [3:0] S_REPLY  = 4'd8;

	logic [3:0]                    state_q;
	logic [mrht_pkg::CNT_W-1:0]    total_q;
	logic [mrht_pkg::IDX_W-1:0]    idx_q;
	logic [mrht_pkg::IDX_BITS-1:0] f_q;
	logic [mrht_pkg::IDX_BITS-1:0] l_q;
	logic [mrht_pkg::IDX_BITS-1:0] tmp_q;
	logic [2:0]                    status_q;
	logic [mrht_pkg::IDX_BITS-1:0] cf_q;
	logic [mrht_pkg::IDX_BITS-1:0] cl_q;
	logic                          done_q;
	mrht_pkg::rsp_t                rsp_q;

	logic [mrht_pkg::IDX_BITS-1:0] alu_a;
	logic [mrht_pkg::IDX_BITS-1:0] alu_b;
	logic [mrht_pkg::IDX_BITS-1:0] alu_c;
	logic                          alu_dec;
	logic                          alu_lt;
	logic                          alu_eq;
	logic [mrht_pkg::IDX_BITS-1:0] alu_adj;
	logic [mrht_pkg::IDX_BITS-1:0] rd_start;
	logic [mrht_pkg::IDX_BITS-1:0] rd_end;
	mrht_pkg::tbl_cmd_t            tbl_cmd;
	logic [mrht_pkg::CNT_W-1:0]    idx_nxt;

	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign rsp     = rsp_q;
	assign idx_nxt = mrht_pkg::CNT_W'(idx_q) + mrht_pkg::CNT_W'(1);

	mrht_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.dec (alu_dec),
		.lt  (alu_lt),
		.eq  (alu_eq),
		.adj (alu_adj)
	);

	mrht_table u_table (
		.clk      (clk),
		.cmd      (tbl_cmd),
		.rd_idx   (idx_q),
		.rd_start (rd_start),
		.rd_end   (rd_end)
	);

	always_comb begin
		alu_a         = rd_end;
		alu_b         = f_q;
		alu_c         = f_q;
		alu_dec       = 1'b0;
		tbl_cmd.op    = mrht_pkg::TBL_NONE;
		tbl_cmd.idx   = idx_q;
		tbl_cmd.val_a = alu_adj;
		tbl_cmd.val_b = alu_adj;
		unique case (state_q)
			S_IDLE: begin
				alu_a = req.range_last;
				alu_b = req.range_first;
				tbl_cmd.val_a = req.range_first;
				tbl_cmd.val_b = req.range_last;
				if (start && req.operation == mrht_pkg::OP_START && !alu_lt)
					tbl_cmd.op = mrht_pkg::TBL_LOAD0;
			end
			S_SEARCH: begin
				alu_a = rd_end;
				alu_b = f_q;
			end
			S_BEFORE: begin
				alu_a   = f_q;
				alu_b   = rd_start;
				alu_c   = rd_start;
				alu_dec = 1'b1;
			end
			S_PAST: begin
				alu_a = rd_end;
				alu_b = l_q;
				alu_c = rd_end;
			end
			S_FRONT: begin
				alu_a = f_q;
				alu_b = rd_start;
			end
			S_TRIM: begin
				alu_a = l_q;
				alu_b = rd_end;
				alu_c = l_q;
				tbl_cmd.op = alu_eq ? mrht_pkg::TBL_DROP : mrht_pkg::TBL_SET_START;
			end
			S_BACK: begin
				alu_a   = l_q;
				alu_b   = rd_end;
				alu_c   = f_q;
				alu_dec = 1'b1;
				if (alu_eq)
					tbl_cmd.op = mrht_pkg::TBL_SET_END;
			end
			S_SPLIT: begin
				alu_c         = l_q;
				tbl_cmd.op    = mrht_pkg::TBL_SPLIT;
				tbl_cmd.val_a = tmp_q;
				tbl_cmd.val_b = alu_adj;
			end
			S_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						f_q      <= req.range_first;
						l_q      <= req.range_last;
						status_q <= mrht_pkg::ST_OK;
						cf_q     <= '0;
						cl_q     <= '0;
						idx_q    <= '0;
						if (req.operation == mrht_pkg::OP_START) begin
							total_q <= alu_lt ? '0 : mrht_pkg::CNT_W'(1);
							state_q <= S_REPLY;
						end else if (total_q == '0) begin
							status_q <= mrht_pkg::ST_DONE;
							state_q  <= S_REPLY;
						end else if (alu_lt) begin
							state_q <= S_REPLY;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (idx_nxt < total_q && alu_lt)
						idx_q <= idx_q + mrht_pkg::IDX_W'(1);
					else
						state_q <= S_BEFORE;
				end
				S_BEFORE: begin
					if (alu_lt) begin
						status_q <= mrht_pkg::ST_BEFORE;
						cf_q     <= f_q;
						cl_q     <= alu_adj;
						state_q  <= S_REPLY;
					end else begin
						state_q <= S_PAST;
					end
				end
				S_PAST: begin
					if (alu_lt) begin
						status_q <= mrht_pkg::ST_PAST;
						cf_q     <= alu_adj;
						cl_q     <= l_q;
						state_q  <= S_REPLY;
					end else begin
						state_q <= S_FRONT;
					end
				end
				S_FRONT: begin
					state_q <= alu_eq ? S_TRIM : S_BACK;
				end
				S_TRIM: begin
					if (alu_eq)
						total_q <= total_q - mrht_pkg::CNT_W'(1);
					state_q <= S_REPLY;
				end
				S_BACK: begin
					if (alu_eq) begin
						state_q <= S_REPLY;
					end else if (total_q >= mrht_pkg::CNT_W'(mrht_pkg::MAX_HOLES)) begin
						status_q <= mrht_pkg::ST_FULL;
						state_q  <= S_REPLY;
					end else begin
						tmp_q   <= alu_adj;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					total_q <= total_q + mrht_pkg::CNT_W'(1);
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					done_q               <= 1'b1;
					rsp_q.status         <= status_q;
					rsp_q.conflict_first <= cf_q;
					rsp_q.conflict_last  <= cl_q;
					rsp_q.holes_left     <= total_q;
					rsp_q.complete       <= total_q == '0;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_after_reply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_REPLY))
		else $error("result strobe without reply state");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= mrht_pkg::CNT_W'(mrht_pkg::MAX_HOLES))
		else $error("hole count above table size");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> mrht_pkg::CNT_W'(idx_q) < total_q)
		else $error("search index past last hole");

	a_complete_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.complete == (rsp.holes_left == '0))
		else $error("complete flag disagrees with hole count");
`endif

endmodule

// File: bench/missing_range_hole_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// missing_range_hole_tracker_tb
// Drives start and fill requests into the hole tracker and keeps its own copy
// of the hole table. Each result strobe is checked field by field against the
// oldest prediction. Directed tests cover the index extremes, collisions, exact
// fills and a full table. Random map sequences follow, with random sender gaps.
// ----------------------------------------------------------------------------
module missing_range_hole_tracker_tb;
	import mrht_pkg::*;

	localparam int STALL_LIMIT = 500;
	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_REQS = 400;
	localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// predicted hole table
	logic [IDX_BITS-1:0] miss_lo [MAX_HOLES];
	logic [IDX_BITS-1:0] miss_hi [MAX_HOLES];
	int miss_count;

	rsp_t want_q[$];
	int mismatches;
	int reqs_sent;
	int results_seen;
	int collisions_seen;
	int full_seen;
	int done_seen;
	bit gaps_on;

	missing_range_hole_tracker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic req_t mk_req(logic op, logic [IDX_BITS-1:0] f, logic [IDX_BITS-1:0] l);
		req_t r;
		r.operation = op;
		r.range_first = f;
		r.range_last = l;
		return r;
	endfunction

	// updates the hole table and returns the result the request should produce
	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		logic [IDX_BITS-1:0] f;
		logic [IDX_BITS-1:0] l;
		int i;
		int k;
		res = '0;
		res.status = ST_OK;
		f = r.range_first;
		l = r.range_last;
		if (r.operation == OP_START) begin
			for (k = 0; k < MAX_HOLES; k++) begin
				miss_lo[k] = '0;
				miss_hi[k] = '0;
			end
			miss_count = 0;
			if (f <= l) begin
				miss_lo[0] = f;
				miss_hi[0] = l;
				miss_count = 1;
			end
		end else if (miss_count == 0) begin
			res.status = ST_DONE;
		end else if (l >= f) begin
			i = 0;
			while (i + 1 < miss_count && miss_hi[i] < f)
				i++;
			if (f < miss_lo[i]) begin
				res.status = ST_BEFORE;
				res.conflict_first = f;
				res.conflict_last = miss_lo[i] - IDX_ONE;
			end else if (l > miss_hi[i]) begin
				res.status = ST_PAST;
				res.conflict_first = miss_hi[i] + IDX_ONE;
				res.conflict_last = l;
			end else if (f == miss_lo[i]) begin
				if (l < miss_hi[i]) begin
					miss_lo[i] = l + IDX_ONE;
				end else begin
					for (k = i; k + 1 < miss_count; k++) begin
						miss_lo[k] = miss_lo[k+1];
						miss_hi[k] = miss_hi[k+1];
					end
					miss_count--;
					miss_lo[miss_count] = '0;
					miss_hi[miss_count] = '0;
				end
			end else if (l == miss_hi[i]) begin
				miss_hi[i] = f - IDX_ONE;
			end else if (miss_count >= MAX_HOLES) begin
				res.status = ST_FULL;
			end else begin
				for (k = miss_count; k > i + 1; k--) begin
					miss_lo[k] = miss_lo[k-1];
					miss_hi[k] = miss_hi[k-1];
				end
				miss_lo[i+1] = l + IDX_ONE;
				miss_hi[i+1] = miss_hi[i];
				miss_hi[i] = f - IDX_ONE;
				miss_count++;
			end
		end
		res.holes_left = CNT_W'(miss_count);
		res.complete = (miss_count == 0);
		return res;
	endfunction

	// interior fill of hole j; needs a hole at least three blocks wide
	function automatic req_t split_req(int j, bit near_front);
		logic [IDX_BITS-1:0] lo;
		logic [IDX_BITS-1:0] hi;
		logic [IDX_BITS-1:0] span;
		logic [IDX_BITS-1:0] f;
		logic [IDX_BITS-1:0] l;
		lo = miss_lo[j];
		hi = miss_hi[j];
		span = hi - lo;
		if (near_front && span > 17)
			f = lo + IDX_ONE + $urandom_range(15, 0);
		else
			f = lo + IDX_ONE + ($urandom % (span - IDX_ONE));
		l = f + $urandom_range(3, 0);
		if (l >= hi || l < f)
			l = hi - IDX_ONE;
		return mk_req(OP_FILL, f, l);
	endfunction

	function automatic req_t make_fill();
		logic [IDX_BITS-1:0] lo;
		logic [IDX_BITS-1:0] hi;
		logic [IDX_BITS-1:0] span;
		logic [IDX_BITS-1:0] gap;
		logic [IDX_BITS-1:0] f;
		logic [IDX_BITS-1:0] l;
		int j;
		int pick;
		if (miss_count == 0 || $urandom_range(19, 0) == 0) begin
			f = $urandom;
			l = ($urandom_range(3, 0) == 0) ? $urandom : f + $urandom_range(15, 0);
			return mk_req(OP_FILL, f, l);
		end
		j = $urandom_range(miss_count - 1, 0);
		lo = miss_lo[j];
		hi = miss_hi[j];
		span = hi - lo;
		pick = $urandom_range(99, 0);
		f = lo;
		l = hi;
		if (pick < 40 && span >= 2) begin
			return split_req(j, $urandom_range(1, 0));
		end else if (pick < 55 && span != 0) begin
			l = lo + ($urandom % span);
		end else if (pick < 70 && span != 0) begin
			f = hi - ($urandom % span);
		end else if (pick < 80) begin
			// exact fill
		end else if (pick < 90) begin
			gap = (j == 0) ? lo : lo - miss_hi[j-1] - IDX_ONE;
			if (gap != 0) begin
				f = lo - IDX_ONE - ($urandom % gap);
				l = lo + $urandom_range(7, 0);
				if (l < f)
					l = hi;
			end
		end else begin
			f = (span == IDX_MAX) ? $urandom : lo + ($urandom % (span + IDX_ONE));
			l = hi + IDX_ONE + $urandom_range(7, 0);
			if (l <= hi)
				l = hi;
		end
		return mk_req(OP_FILL, f, l);
	endfunction

	function automatic req_t make_start();
		logic [IDX_BITS-1:0] f;
		logic [IDX_BITS-1:0] l;
		logic [IDX_BITS-1:0] span;
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 5) begin
			l = $urandom;
			f = l + $urandom_range(64, 1);
		end else if (pick < 15) begin
			f = $urandom;
			l = $urandom;
			if (f > l)
				{f, l} = {l, f};
		end else begin
			span = $urandom_range(4000, 20);
			f = $urandom;
			if (f > IDX_MAX - span)
				f = IDX_MAX - span;
			l = f + span;
		end
		return mk_req(OP_START, f, l);
	endfunction

	task automatic send_req(req_t r);
		if (gaps_on && $urandom_range(5, 0) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		want_q.push_back(apply_request(r));
		reqs_sent++;
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do @(posedge clk); while (want_q.size() != 0);
	endtask

	function automatic void check_field(string name, logic [IDX_BITS-1:0] want,
			logic [IDX_BITS-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (done) begin
			if (want_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual %0h", $time, rsp);
			end else begin
				want = want_q.pop_front();
				results_seen++;
				if (want.status == ST_BEFORE || want.status == ST_PAST)
					collisions_seen++;
				if (want.status == ST_FULL)
					full_seen++;
				if (want.status == ST_DONE)
					done_seen++;
				check_field("status", IDX_BITS'(want.status), IDX_BITS'(rsp.status));
				check_field("conflict_first", want.conflict_first, rsp.conflict_first);
				check_field("conflict_last", want.conflict_last, rsp.conflict_last);
				check_field("holes_left", IDX_BITS'(want.holes_left),
					IDX_BITS'(rsp.holes_left));
				check_field("complete", IDX_BITS'(want.complete), IDX_BITS'(rsp.complete));
			end
		end
	end

	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: timeout, %0d results outstanding", $time, want_q.size());
		$display("missing_range_hole_tracker_tb: FAIL");
		$finish;
	end

	task automatic test_fill_on_empty_map();
		send_req(mk_req(OP_FILL, '0, IDX_MAX));
	endtask

	task automatic test_index_extremes();
		send_req(mk_req(OP_START, '0, IDX_MAX));
		send_req(mk_req(OP_FILL, '0, '0));
		send_req(mk_req(OP_FILL, IDX_MAX, IDX_MAX));
		send_req(mk_req(OP_FILL, 32'h10, 32'h1F));
		send_req(mk_req(OP_FILL, '0, 32'h5));
		send_req(mk_req(OP_FILL, 32'hF, 32'h20));
		// past every hole
		send_req(mk_req(OP_FILL, IDX_MAX, IDX_MAX));
		// reversed fill
		send_req(mk_req(OP_FILL, 32'h5, 32'h3));
	endtask

	task automatic test_exact_hole_fills();
		send_req(mk_req(OP_START, 32'd100, 32'd199));
		send_req(mk_req(OP_FILL, 32'd120, 32'd129));
		send_req(mk_req(OP_FILL, 32'd150, 32'd159));
		send_req(mk_req(OP_FILL, 32'd130, 32'd149));
		send_req(mk_req(OP_FILL, 32'd160, 32'd199));
		send_req(mk_req(OP_FILL, 32'd100, 32'd119));
		send_req(mk_req(OP_FILL, 32'd100, 32'd100));
	endtask

	task automatic test_empty_start();
		send_req(mk_req(OP_START, 32'd10, 32'd5));
		send_req(mk_req(OP_FILL, 32'd5, 32'd10));
	endtask

	task automatic test_table_full();
		int j;
		send_req(mk_req(OP_START, 32'd1000, 32'd1999));
		repeat (MAX_HOLES - 1) send_req(split_req(miss_count - 1, 1'b1));
		send_req(split_req(miss_count - 1, 1'b1));
		send_req(mk_req(OP_FILL, miss_lo[0], miss_lo[0]));
		j = miss_count / 2;
		send_req(mk_req(OP_FILL, miss_lo[j], miss_hi[j]));
		send_req(split_req(miss_count - 1, 1'b1));
	endtask

	task automatic test_random_sequences(int n);
		int k;
		int len;
		k = 0;
		while (k < n) begin
			gaps_on = (k < n - 70);
			send_req(make_start());
			len = $urandom_range(45, 8);
			repeat (len) begin
				gaps_on = (k < n - 70);
				send_req(make_fill());
				k++;
			end
			k++;
			if (k < n - 70 && $urandom_range(3, 0) == 0)
				wait_all_results();
		end
	endtask

	initial begin
		mismatches = 0;
		reqs_sent = 0;
		results_seen = 0;
		collisions_seen = 0;
		full_seen = 0;
		done_seen = 0;
		miss_count = 0;
		gaps_on = 1'b1;
		for (int k = 0; k < MAX_HOLES; k++) begin
			miss_lo[k] = '0;
			miss_hi[k] = '0;
		end
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_on_empty_map();
		test_index_extremes();
		wait_all_results();
		test_exact_hole_fills();
		test_empty_start();
		wait_all_results();
		test_table_full();
		wait_all_results();
		test_random_sequences(RANDOM_REQS);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d mismatches", reqs_sent,
			results_seen, mismatches);
		$display("seen: %0d collisions, %0d full-table splits, %0d fills on a complete map",
			collisions_seen, full_seen, done_seen);
		if (mismatches == 0)
			$display("missing_range_hole_tracker_tb: PASS");
		else
			$display("missing_range_hole_tracker_tb: FAIL");
		$finish;
	end

endmodule

// File: files.f
src/mrht_pkg.sv
src/mrht_alu.sv
src/mrht_table.sv
src/missing_range_hole_tracker.sv
bench/missing_range_hole_tracker_tb.sv
